// ===== design/sil_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the sorted insertion list
package sil_pkg;

	localparam int POS_W = 4;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [2:0] {
		KIND_ADD          = 3'd0,
		KIND_REMOVE_VALUE = 3'd1,
		KIND_CONTAINS     = 3'd2,
		KIND_READ_INDEX   = 3'd3,
		KIND_REMOVE_INDEX = 3'd4,
		KIND_CLEAR        = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_INSERT,
		MODE_DROP_VALUE,
		MODE_DROP_INDEX
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic               found;
		logic [POS_W-1:0]   pos;
	} cell_cmd_t;

endpackage

// ===== design/sil_cell.sv =====
`timescale 1ns / 1ps
// one entry of the sorted chain: compare against the item and shift left or right
module sil_cell
	import sil_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int INDEX = 0
) (
	input  logic                         clk,
	input  logic                         valid,
	input  cell_cmd_t                    cmd,
	input  logic signed [VALUE_BITS-1:0] item_value,
	input  logic signed [VALUE_BITS-1:0] left_value,
	input  logic signed [VALUE_BITS-1:0] right_value,
	input  logic                         left_gt,
	output logic                         gt,
	output logic                         eq,
	output logic signed [VALUE_BITS-1:0] entry
);

	logic signed [VALUE_BITS-1:0] entry_q;
	logic signed [VALUE_BITS-1:0] entry_nxt;
	logic                         ge;
	logic                         at_or_after_pos;

	assign gt = valid && (entry_q > item_value);
	assign eq = valid && (entry_q == item_value);
	assign ge = entry_q >= item_value;
	assign at_or_after_pos = INDEX >= int'(cmd.pos);
	assign entry = entry_q;

	always_comb begin
		entry_nxt = entry_q;
		case (cmd.mode)
			MODE_INSERT: begin
				if (left_gt) begin
					entry_nxt = left_value;
				end else if (gt || !valid) begin
					entry_nxt = item_value;
				end
			end
			MODE_DROP_VALUE: begin
				if (cmd.found && ge) begin
					entry_nxt = right_value;
				end
			end
			MODE_DROP_INDEX: begin
				if (at_or_after_pos) begin
					entry_nxt = right_value;
				end
			end
			default: begin
				entry_nxt = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

endmodule

// ===== design/sorted_insertion_list.sv =====
`timescale 1ns / 1ps
// sorted insertion list top level: request decode, cell chain and result registers
// a result is registered first in the item stage and then in the output register
// throughput: one item per cycle while in_stall is low, set by the compare-and-shift of the cell chain
// the item stage and the output register decouple input from a stalled output
// reset: arst_n clears the entry count and all valid flags; entries are not reset
module sorted_insertion_list
	import sil_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   kind,
	input  logic signed [VALUE_BITS-1:0] item_value,
	input  logic [POS_W-1:0]             position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic                         found,
	output logic signed [VALUE_BITS-1:0] read_value,
	output logic [COUNT_OUT_W-1:0]       entry_count,
	output logic signed [VALUE_BITS-1:0] smallest,
	output logic signed [VALUE_BITS-1:0] largest
);

	localparam int CntW = $clog2(CAPACITY + 1);
	localparam int CmpW = CntW + POS_W;

	logic [CntW-1:0]              count_q;
	logic [CntW-1:0]              count_nxt;
	logic [CAPACITY-1:0]          cell_valid;
	logic [CAPACITY-1:0]          cell_gt;
	logic [CAPACITY-1:0]          cell_eq;
	logic signed [VALUE_BITS-1:0] cell_entry [CAPACITY];
	cell_cmd_t                    cmd;
	logic                         accept;
	logic                         full;
	logic                         in_range;
	logic                         found_any;
	logic signed [VALUE_BITS-1:0] sel_value;

	logic                         pend_valid_s1;
	status_t                      status_s1;
	logic                         found_s1;
	logic signed [VALUE_BITS-1:0] read_s1;
	status_t                      status_nxt;
	logic                         found_nxt;
	logic signed [VALUE_BITS-1:0] read_nxt;
	logic                         pend_move;

	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic                         found_q;
	logic signed [VALUE_BITS-1:0] read_q;
	logic [COUNT_OUT_W-1:0]       count_out_q;
	logic signed [VALUE_BITS-1:0] smallest_q;
	logic signed [VALUE_BITS-1:0] largest_q;
	logic signed [VALUE_BITS-1:0] largest_sel;

	assign pend_move = pend_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = pend_valid_s1 && out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;
	assign full = count_q == CntW'(CAPACITY);
	assign in_range = CmpW'(position) < CmpW'(count_q);
	assign found_any = |cell_eq;

	always_comb begin
		sel_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CmpW'(position) == CmpW'(i)) begin
				sel_value = cell_entry[i];
			end
		end
	end

	// request decode
	always_comb begin
		cmd.mode = MODE_HOLD;
		cmd.found = found_any;
		cmd.pos = position;
		count_nxt = count_q;
		status_nxt = STATUS_OK;
		found_nxt = 1'b0;
		read_nxt = '0;
		case (kind)
			KIND_ADD: begin
				if (full) begin
					status_nxt = STATUS_FULL;
				end else begin
					cmd.mode = MODE_INSERT;
					count_nxt = count_q + CntW'(1);
				end
			end
			KIND_REMOVE_VALUE: begin
				cmd.mode = MODE_DROP_VALUE;
				found_nxt = found_any;
				if (found_any) begin
					count_nxt = count_q - CntW'(1);
				end
			end
			KIND_CONTAINS: begin
				found_nxt = found_any;
			end
			KIND_READ_INDEX: begin
				if (in_range) begin
					read_nxt = sel_value;
				end else begin
					status_nxt = STATUS_RANGE;
				end
			end
			KIND_REMOVE_INDEX: begin
				if (in_range) begin
					cmd.mode = MODE_DROP_INDEX;
					read_nxt = sel_value;
					found_nxt = 1'b1;
					count_nxt = count_q - CntW'(1);
				end else begin
					status_nxt = STATUS_RANGE;
				end
			end
			KIND_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
		if (!accept) begin
			cmd.mode = MODE_HOLD;
			count_nxt = count_q;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_valid[i] = CntW'(i) < count_q;
		sil_cell #(
			.VALUE_BITS(VALUE_BITS),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.valid(cell_valid[i]),
			.cmd(cmd),
			.item_value(item_value),
			.left_value((i == 0) ? item_value : cell_entry[(i == 0) ? 0 : i - 1]),
			.right_value((i == CAPACITY - 1) ? item_value
				: cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
			.left_gt((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
			.gt(cell_gt[i]),
			.eq(cell_eq[i]),
			.entry(cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				pend_valid_s1 <= 1'b1;
			end else if (pend_move) begin
				pend_valid_s1 <= 1'b0;
			end
			if (pend_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_nxt;
			found_s1 <= found_nxt;
			read_s1 <= read_nxt;
		end
	end

	// last occupied cell
	always_comb begin
		largest_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (count_q == CntW'(i + 1)) begin
				largest_sel = cell_entry[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			status_q <= status_s1;
			found_q <= found_s1;
			read_q <= read_s1;
			count_out_q <= COUNT_OUT_W'(count_q);
			smallest_q <= (count_q != '0) ? cell_entry[0] : '0;
			largest_q <= largest_sel;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign found = found_q;
	assign read_value = read_q;
	assign entry_count = count_out_q;
	assign smallest = smallest_q;
	assign largest = largest_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend_valid_s1)
		else $error("accepted item not pending");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_CLEAR) |=> (count_q == '0))
		else $error("clear left entries");

	a_full_add_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_ADD && full) |=> (count_q == CntW'(CAPACITY)))
		else $error("add to full store changed count");
`endif

endmodule
